// ----- hdl/phsvc_pkg.sv -----
`timescale 1ns / 1ps

package phsvc_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned VOXEL_BITS = 16;
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned SIDE_BITS  = 27 + FRAC_BITS + 1;
  localparam int unsigned STEP_BITS  = 11 + FRAC_BITS + 1;
  localparam int unsigned DIM_BITS   = $clog2(MAX_DIM);
  localparam int unsigned SIZE_BITS  = DIM_BITS + 1;
  localparam int unsigned CFG_DATA_BITS = SIDE_BITS;
  localparam int unsigned CFG_IDX_BITS  = 3;

  typedef logic signed [SIDE_BITS-1:0] side_t;
  typedef logic signed [STEP_BITS-1:0] step_t;
  typedef logic [DIM_BITS-1:0]         dim_t;
  typedef logic [SIZE_BITS-1:0]        size_t;
  typedef logic [VOXEL_BITS-1:0]       voxel_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SIDE_AT_ORIGIN   = 3'd0,
    REG_I_STEP           = 3'd1,
    REG_J_STEP           = 3'd2,
    REG_K_STEP           = 3'd3,
    REG_ROW_LENGTH       = 3'd4,
    REG_ROWS_PER_SLICE   = 3'd5,
    REG_KEEP_INSIDE      = 3'd6,
    REG_BACKGROUND_VALUE = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    side_t  side_at_origin;
    step_t  i_step;
    step_t  j_step;
    step_t  k_step;
    size_t  row_length;
    size_t  rows_per_slice;
    logic   keep_inside;
    voxel_t background_value;
  } cfg_t;

  typedef struct packed {
    voxel_t value;
    logic   kept;
  } res_t;

  // Distance add clamped to the signed distance range.
  function automatic side_t sat_add(side_t a, step_t b);
    logic signed [SIDE_BITS:0] sum;
    side_t                     res;
    sum = {a[SIDE_BITS-1], a} + (SIDE_BITS+1)'(b);
    if (sum[SIDE_BITS] != sum[SIDE_BITS-1]) begin
      res = sum[SIDE_BITS] ? {1'b1, {(SIDE_BITS-1){1'b0}}} : {1'b0, {(SIDE_BITS-1){1'b1}}};
    end else begin
      res = sum[SIDE_BITS-1:0];
    end
    return res;
  endfunction

  // Size zero counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic size_t eff_size(size_t v);
    size_t res;
    if (v == '0) begin
      res = SIZE_BITS'(1);
    end else if (v > SIZE_BITS'(MAX_DIM)) begin
      res = SIZE_BITS'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- hdl/plane_half_space_voxel_crop.sv -----
`timescale 1ns / 1ps
// A result is computed combinationally and registered in the output buffer.
// Throughput: one voxel per cycle; a two-entry output buffer takes a new
// voxel while one result waits, and stall rises only when both are held.
// Reset (async, active low): position and distances clear, registers
// return to their defaults, output buffer empties.

module plane_half_space_voxel_crop (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [phsvc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [phsvc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [phsvc_pkg::VOXEL_BITS-1:0]      voxel_value_i,
  input  logic                                  start_of_volume_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [phsvc_pkg::VOXEL_BITS-1:0]      out_value_o,
  output logic                                  kept_o
);

  phsvc_pkg::cfg_t cfg_q;
  phsvc_pkg::res_t res, out_res;
  logic            accept, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side_at_origin   <= '0;
      cfg_q.i_step           <= '0;
      cfg_q.j_step           <= '0;
      cfg_q.k_step           <= '0;
      cfg_q.row_length       <= phsvc_pkg::SIZE_BITS'(1);
      cfg_q.rows_per_slice   <= phsvc_pkg::SIZE_BITS'(1);
      cfg_q.keep_inside      <= 1'b1;
      cfg_q.background_value <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phsvc_pkg::REG_SIDE_AT_ORIGIN: begin
          cfg_q.side_at_origin <= cfg_data_i[phsvc_pkg::SIDE_BITS-1:0];
        end
        phsvc_pkg::REG_I_STEP: begin
          cfg_q.i_step <= cfg_data_i[phsvc_pkg::STEP_BITS-1:0];
        end
        phsvc_pkg::REG_J_STEP: begin
          cfg_q.j_step <= cfg_data_i[phsvc_pkg::STEP_BITS-1:0];
        end
        phsvc_pkg::REG_K_STEP: begin
          cfg_q.k_step <= cfg_data_i[phsvc_pkg::STEP_BITS-1:0];
        end
        phsvc_pkg::REG_ROW_LENGTH: begin
          cfg_q.row_length <= cfg_data_i[phsvc_pkg::SIZE_BITS-1:0];
        end
        phsvc_pkg::REG_ROWS_PER_SLICE: begin
          cfg_q.rows_per_slice <= cfg_data_i[phsvc_pkg::SIZE_BITS-1:0];
        end
        phsvc_pkg::REG_KEEP_INSIDE: begin
          cfg_q.keep_inside <= cfg_data_i[0];
        end
        phsvc_pkg::REG_BACKGROUND_VALUE: begin
          cfg_q.background_value <= cfg_data_i[phsvc_pkg::VOXEL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  phsvc_tracker u_tracker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .en_i              (accept),
    .voxel_value_i     (voxel_value_i),
    .start_of_volume_i (start_of_volume_i),
    .res_o             (res)
  );

  phsvc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_res_i  (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign out_value_o = out_res.value;
  assign kept_o      = out_res.kept;

endmodule

// ----- hdl/phsvc_tracker.sv -----
`timescale 1ns / 1ps

module phsvc_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phsvc_pkg::cfg_t     cfg_i,
  input  logic                en_i,
  input  phsvc_pkg::voxel_t   voxel_value_i,
  input  logic                start_of_volume_i,
  output phsvc_pkg::res_t     res_o
);

  phsvc_pkg::dim_t  col_q, col_d, row_q, row_d, slc_q, slc_d;
  phsvc_pkg::dim_t  col_c, row_c, slc_c;
  phsvc_pkg::side_t run_q, run_d, row_side_q, row_side_d, slc_side_q, slc_side_d;
  phsvc_pkg::side_t run_c, row_side_c, slc_side_c;
  phsvc_pkg::size_t len, rows;
  logic             col_end, row_end, normal_side, keep;

  assign len  = phsvc_pkg::eff_size(cfg_i.row_length);
  assign rows = phsvc_pkg::eff_size(cfg_i.rows_per_slice);

  // start of volume overrides the stored position before judging
  assign col_c      = start_of_volume_i ? '0 : col_q;
  assign row_c      = start_of_volume_i ? '0 : row_q;
  assign slc_c      = start_of_volume_i ? '0 : slc_q;
  assign run_c      = start_of_volume_i ? cfg_i.side_at_origin : run_q;
  assign row_side_c = start_of_volume_i ? cfg_i.side_at_origin : row_side_q;
  assign slc_side_c = start_of_volume_i ? cfg_i.side_at_origin : slc_side_q;

  assign normal_side = !run_c[phsvc_pkg::SIDE_BITS-1] && (run_c != '0);
  assign keep        = cfg_i.keep_inside ? normal_side : !normal_side;

  assign res_o.kept  = keep;
  assign res_o.value = keep ? voxel_value_i : cfg_i.background_value;

  assign col_end = ({1'b0, col_c} + phsvc_pkg::SIZE_BITS'(1)) >= len;
  assign row_end = ({1'b0, row_c} + phsvc_pkg::SIZE_BITS'(1)) >= rows;

  always_comb begin
    col_d      = col_c;
    row_d      = row_c;
    slc_d      = slc_c;
    run_d      = run_c;
    row_side_d = row_side_c;
    slc_side_d = slc_side_c;
    if (!col_end) begin
      col_d = col_c + phsvc_pkg::DIM_BITS'(1);
      run_d = phsvc_pkg::sat_add(run_c, cfg_i.i_step);
    end else begin
      col_d = '0;
      if (!row_end) begin
        row_d      = row_c + phsvc_pkg::DIM_BITS'(1);
        row_side_d = phsvc_pkg::sat_add(row_side_c, cfg_i.j_step);
      end else begin
        row_d      = '0;
        slc_d      = slc_c + phsvc_pkg::DIM_BITS'(1);
        slc_side_d = phsvc_pkg::sat_add(slc_side_c, cfg_i.k_step);
        row_side_d = slc_side_d;
      end
      run_d = row_side_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      slc_q      <= '0;
      run_q      <= '0;
      row_side_q <= '0;
      slc_side_q <= '0;
    end else if (en_i) begin
      col_q      <= col_d;
      row_q      <= row_d;
      slc_q      <= slc_d;
      run_q      <= run_d;
      row_side_q <= row_side_d;
      slc_side_q <= slc_side_d;
    end
  end

endmodule

// ----- hdl/phsvc_out_buf.sv -----
`timescale 1ns / 1ps

module phsvc_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  phsvc_pkg::res_t push_res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output phsvc_pkg::res_t out_res_o
);

  logic            main_v_q, main_v_d, skid_v_q, skid_v_d;
  phsvc_pkg::res_t main_q, main_d, skid_q, skid_d;

  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!main_v_q || !out_stall_i) begin
      main_v_d = skid_v_q || push_i;
      main_d   = skid_v_q ? skid_q : push_res_i;
      skid_v_d = 1'b0;
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;

endmodule

// ----- hdl/phsvc_checker.sv -----
`timescale 1ns / 1ps

module phsvc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [phsvc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input logic [phsvc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [phsvc_pkg::VOXEL_BITS-1:0]    voxel_value_i,
  input logic                                start_of_volume_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [phsvc_pkg::VOXEL_BITS-1:0]    out_value_o,
  input logic                                kept_o
);

  // stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_value_o) && $stable(kept_o))
    else $error("stalled result changed");

  // input stall only while a result is held
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // after every input transfer a result is valid in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result after input transfer");

  // input stall rises only after the output was stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i && in_valid_i))
    else $error("input stall without output stall");

endmodule

bind plane_half_space_voxel_crop phsvc_checker u_phsvc_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

import phsvc_pkg::*;

typedef logic signed [47:0] dist_t;

localparam dist_t DIST_MAX = {1'b0, {47{1'b1}}};
localparam dist_t DIST_MIN = {1'b1, {47{1'b0}}};
localparam step_t STEP_MAX = {1'b0, {31{1'b1}}};
localparam step_t STEP_MIN = {1'b1, {31{1'b0}}};

class voxel_crop_checker;
  localparam int MAX_REPORTS = 40;

  dist_t  origin;
  step_t  col_step;
  step_t  row_step;
  step_t  slice_step;
  size_t  row_len;
  size_t  slice_rows;
  logic   keep_normal;
  voxel_t background;

  dim_t  col;
  dim_t  row;
  dim_t  slice;
  dist_t run_dist;
  dist_t row_dist;
  dist_t slice_dist;

  res_t expected_voxels[$];

  int errors;
  int checked;
  int kept_count;
  int removed_count;
  int starts;
  int clamps;

  function new();
    origin      = '0;
    col_step    = '0;
    row_step    = '0;
    slice_step  = '0;
    row_len     = size_t'(1);
    slice_rows  = size_t'(1);
    keep_normal = 1'b1;
    background  = '0;
    col         = '0;
    row         = '0;
    slice       = '0;
    run_dist    = '0;
    row_dist    = '0;
    slice_dist  = '0;
  endfunction

  function int pending();
    return expected_voxels.size();
  endfunction

  function void write_reg(cfg_idx_e idx, logic [63:0] value);
    case (idx)
      REG_SIDE_AT_ORIGIN:   origin = value[47:0];
      REG_I_STEP:           col_step = value[31:0];
      REG_J_STEP:           row_step = value[31:0];
      REG_K_STEP:           slice_step = value[31:0];
      REG_ROW_LENGTH:       row_len = value[12:0];
      REG_ROWS_PER_SLICE:   slice_rows = value[12:0];
      REG_KEEP_INSIDE:      keep_normal = value[0];
      REG_BACKGROUND_VALUE: background = value[15:0];
      default: ;
    endcase
  endfunction

  function dist_t clamp_add(dist_t a, step_t b);
    logic signed [48:0] sum;
    sum = a;
    sum = sum + b;
    if (sum > 49'sh0_7FFF_FFFF_FFFF) begin
      clamps++;
      return DIST_MAX;
    end
    if (sum < -49'sh0_8000_0000_0000) begin
      clamps++;
      return DIST_MIN;
    end
    return sum[47:0];
  endfunction

  function size_t active_size(size_t v);
    if (v == '0) return size_t'(1);
    if (v > size_t'(MAX_DIM)) return size_t'(MAX_DIM);
    return v;
  endfunction

  function void note_voxel(voxel_t v, logic sov);
    size_t len;
    size_t nrows;
    logic  normal;
    logic  keep;
    res_t  r;
    len   = active_size(row_len);
    nrows = active_size(slice_rows);
    if (sov) begin
      col        = '0;
      row        = '0;
      slice      = '0;
      run_dist   = origin;
      row_dist   = origin;
      slice_dist = origin;
      starts++;
    end
    normal  = run_dist > 0;
    keep    = keep_normal ? normal : !normal;
    r.value = keep ? v : background;
    r.kept  = keep;
    expected_voxels.push_back(r);
    if (int'(col) + 1 < int'(len)) begin
      col++;
      run_dist = clamp_add(run_dist, col_step);
    end else begin
      col = '0;
      if (int'(row) + 1 < int'(nrows)) begin
        row++;
        row_dist = clamp_add(row_dist, row_step);
      end else begin
        row        = '0;
        slice      = (int'(slice) + 1 >= MAX_DIM) ? '0 : slice + 1'b1;
        slice_dist = clamp_add(slice_dist, slice_step);
        row_dist   = slice_dist;
      end
      run_dist = row_dist;
    end
  endfunction

  function void check_result(voxel_t v, logic k);
    res_t exp_r;
    if (expected_voxels.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("%0t: result with none expected: value %h kept %b", $time, v, k);
      errors++;
      return;
    end
    exp_r = expected_voxels.pop_front();
    checked++;
    if (exp_r.kept) kept_count++;
    else removed_count++;
    if (exp_r.value !== v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: out_value expected %h, actual %h", $time, exp_r.value, v);
      errors++;
    end
    if (exp_r.kept !== k) begin
      if (errors < MAX_REPORTS)
        $display("%0t: kept expected %b, actual %b", $time, exp_r.kept, k);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 300000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  voxel_t                   voxel_value_i;
  logic                     start_of_volume_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  voxel_t                   out_value_o;
  logic                     kept_o;

  voxel_crop_checker sb;
  bit                send_quiet = 1'b0;
  bit                recv_quiet = 1'b0;
  bit                hold_req = 1'b0;
  int                settings = 0;
  int                sent = 0;
  int unsigned       cycle_count = 0;

  plane_half_space_voxel_crop DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .voxel_value_i     (voxel_value_i),
    .start_of_volume_i (start_of_volume_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_value_o       (out_value_o),
    .kept_o            (kept_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_result(out_value_o, kept_o);
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        sb.note_voxel(voxel_value_i, start_of_volume_i);
    end
  end

  // result side: random stall per transfer, quiet stretches, long hold on request
  initial begin : receiver
    int gap;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = recv_quiet ? 0 : $urandom_range(0, 8);
      end
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  task automatic send_voxel(voxel_t v, logic sov);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    voxel_value_i     <= v;
    start_of_volume_i <= sov;
    do @(posedge clk_i); while (!(in_valid_i === 1'b1 && in_stall_o === 1'b0));
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_BITS-1:0];
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic set_config(dist_t origin, step_t di, step_t dj, step_t dk,
                            size_t len, size_t nrows, logic keep, voxel_t bg);
    write_reg(REG_SIDE_AT_ORIGIN, 64'(origin));
    write_reg(REG_I_STEP, 64'(di));
    write_reg(REG_J_STEP, 64'(dj));
    write_reg(REG_K_STEP, 64'(dk));
    write_reg(REG_ROW_LENGTH, 64'(len));
    write_reg(REG_ROWS_PER_SLICE, 64'(nrows));
    write_reg(REG_KEEP_INSIDE, 64'(keep));
    write_reg(REG_BACKGROUND_VALUE, 64'(bg));
    close_writes();
  endtask

  function automatic step_t pick_step();
    case ($urandom_range(0, 5))
      0: return step_t'($urandom);
      1: return STEP_MAX;
      2: return STEP_MIN;
      default: return step_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic dist_t pick_origin();
    case ($urandom_range(0, 5))
      0: return dist_t'({$urandom, $urandom});
      1: return DIST_MAX - dist_t'($urandom_range(0, 1 << 24));
      2: return DIST_MIN + dist_t'($urandom_range(0, 1 << 24));
      default: return dist_t'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic size_t pick_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return size_t'(MAX_DIM);
      2: return size_t'($urandom_range(MAX_DIM + 1, 8191));
      default: return size_t'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic voxel_t pick_background();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return voxel_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(int phase_no);
    size_t len;
    size_t nrows;
    int    n;
    int    vol;
    int    pos;
    logic  sov;
    bit    hold_phase;
    len   = pick_size();
    nrows = pick_size();
    set_config(pick_origin(), pick_step(), pick_step(), pick_step(), len, nrows,
               logic'($urandom_range(0, 1)), pick_background());
    hold_phase = (phase_no % 9 == 3);
    send_quiet = hold_phase || ($urandom_range(0, 3) == 0);
    n   = hold_phase ? 60 : $urandom_range(20, 100);
    vol = int'(len) * int'(nrows) * $urandom_range(1, 3);
    if (vol < 1) vol = 1;
    if (vol > 200) vol = 200;
    pos = 0;
    for (int t = 0; t < n; t++) begin
      if (hold_phase && t == 5) hold_req = 1'b1;
      sov = (pos == 0);
      // occasional dropped or spurious start marks
      if ($urandom_range(0, 19) == 0) sov = !sov;
      if (sov) pos = 0;
      send_voxel(voxel_t'($urandom), sov);
      pos++;
      if (pos >= vol) pos = 0;
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int phase_no;
    sb                = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_SIDE_AT_ORIGIN;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    voxel_value_i     = '0;
    start_of_volume_i = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // before any start: distance zero, not on the normal side
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'hFFFF, 1'b0);
    wait_idle();

    // small volume crossing zero exactly, through row and slice ends
    set_config(dist_t'(1), -32'sd1, 32'sd3, -32'sd2, 13'd3, 13'd2, 1'b1, 16'hA5A5);
    send_voxel(16'hFFFF, 1'b1);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h1234, 1'b0);
    send_voxel(16'hFFFF, 1'b0);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h8001, 1'b0);
    send_voxel(16'h7FFE, 1'b0);
    wait_idle();

    // positive clamping, inverted selection
    set_config(DIST_MAX, STEP_MAX, STEP_MIN, STEP_MAX, 13'd2, 13'd1, 1'b0, 16'hFFFF);
    send_voxel(16'h5A5A, 1'b1);
    send_voxel(16'hFFFF, 1'b0);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h00FF, 1'b0);
    wait_idle();

    // negative clamping, then row length lowered mid-row and origin changed without start
    set_config(DIST_MIN, STEP_MIN, STEP_MIN, STEP_MAX, 13'd8, 13'd1, 1'b1, 16'h0000);
    send_voxel(16'hFFFF, 1'b1);
    send_voxel(16'h0001, 1'b0);
    send_voxel(16'h8000, 1'b0);
    send_voxel(16'h7FFF, 1'b0);
    wait_idle();
    write_reg(REG_ROW_LENGTH, 64'd2);
    write_reg(REG_SIDE_AT_ORIGIN, 64'd1 << 20);
    close_writes();
    send_voxel(16'hFFFF, 1'b0);
    send_voxel(16'hC3C3, 1'b0);
    wait_idle();

    // zero row length counts as one, oversized slice as the maximum
    write_reg(REG_ROW_LENGTH, 64'd0);
    write_reg(REG_ROWS_PER_SLICE, 64'd8191);
    write_reg(REG_J_STEP, 64'(-64'sd700000));
    close_writes();
    send_voxel(16'hFFFF, 1'b1);
    send_voxel(16'h0000, 1'b0);
    send_voxel(16'h3C3C, 1'b0);
    wait_idle();

    phase_no = 0;
    while (sent < RANDOM_ITEMS + 25) begin
      random_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("%0d voxels checked under %0d register settings: %0d kept, %0d background",
             sb.checked, settings, sb.kept_count, sb.removed_count);
    $display("%0d volume starts, %0d clamped distance updates, %0d errors",
             sb.starts, sb.clamps, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
